### hw/rtl/sall_pkg.sv
// Shared types and constants for the sorted array linked list.
package sall_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 64;
  localparam int KEY_W        = 64;
  localparam int SLOT_W       = 4;
  localparam int COUNT_W      = 4;
  localparam int MAX_OUT      = 15;
  localparam int LIST_W       = 4;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_SEARCH = 2'd2,
    FN_LIST   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_FOUND    = 3'd6,
    ST_LISTED   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    SLOT_NONE = 2'd0,
    SLOT_CUR  = 2'd1,
    SLOT_FREE = 2'd2
  } slot_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_DECIDE,
    S_SCAN,
    S_LINK_NEW,
    S_LINK_PREV,
    S_RESP,
    S_LIST
  } state_t;

  typedef struct packed {
    logic      load_in;
    logic      start_walk;
    logic      step;
    logic      unlink;
    logic      scan_init;
    logic      scan_step;
    logic      link_new;
    logic      link_prev;
    logic      set_res;
    status_t   res_status;
    slot_sel_t slot_sel;
    logic      clr_key;
    logic      emit_res;
    logic      emit_list;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  full;
    logic  empty;
    logic  head_zero;
    logic  link_zero;
    logic  key_ge;
    logic  found;
    logic  free_hit;
    logic  scan_end;
    logic  list_end;
    logic  out_free;
  } sts_t;

endpackage

### hw/rtl/sall_ctrl.sv
// Controller state machine: sequences walk, free-cell scan, relink and result steps.
module sall_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sall_pkg::sts_t  sts,
  output sall_pkg::cmd_t  cmd,
  output sall_pkg::state_t state_out
);

  sall_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sall_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sall_pkg::S_IDLE: begin
        if (req_valid) state_next = sall_pkg::S_START;
      end
      sall_pkg::S_START: begin
        unique case (sts.func)
          sall_pkg::FN_INSERT: begin
            if (sts.full) state_next = sall_pkg::S_RESP;
            else if (sts.head_zero) state_next = sall_pkg::S_DECIDE;
            else state_next = sall_pkg::S_WALK;
          end
          sall_pkg::FN_DELETE: begin
            if (sts.empty) state_next = sall_pkg::S_RESP;
            else if (sts.head_zero) state_next = sall_pkg::S_DECIDE;
            else state_next = sall_pkg::S_WALK;
          end
          sall_pkg::FN_SEARCH: begin
            if (sts.head_zero) state_next = sall_pkg::S_DECIDE;
            else state_next = sall_pkg::S_WALK;
          end
          sall_pkg::FN_LIST: begin
            if (sts.head_zero) state_next = sall_pkg::S_RESP;
            else state_next = sall_pkg::S_LIST;
          end
          default: state_next = sall_pkg::S_IDLE;
        endcase
      end
      sall_pkg::S_WALK: begin
        if (sts.key_ge || sts.link_zero) state_next = sall_pkg::S_DECIDE;
      end
      sall_pkg::S_DECIDE: begin
        if (sts.func == sall_pkg::FN_INSERT && !sts.found) state_next = sall_pkg::S_SCAN;
        else state_next = sall_pkg::S_RESP;
      end
      sall_pkg::S_SCAN: begin
        if (sts.free_hit) state_next = sall_pkg::S_LINK_NEW;
        else if (sts.scan_end) state_next = sall_pkg::S_RESP;
      end
      sall_pkg::S_LINK_NEW:  state_next = sall_pkg::S_LINK_PREV;
      sall_pkg::S_LINK_PREV: state_next = sall_pkg::S_RESP;
      sall_pkg::S_RESP: begin
        if (sts.out_free) state_next = sall_pkg::S_IDLE;
      end
      sall_pkg::S_LIST: begin
        if (sts.out_free && sts.list_end) state_next = sall_pkg::S_IDLE;
      end
      default: state_next = sall_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.res_status = sall_pkg::ST_INSERTED;
    cmd.slot_sel   = sall_pkg::SLOT_NONE;
    req_ready      = 1'b0;
    unique case (state)
      sall_pkg::S_IDLE: begin
        req_ready   = 1'b1;
        cmd.load_in = req_valid;
      end
      sall_pkg::S_START: begin
        unique case (sts.func)
          sall_pkg::FN_INSERT: begin
            if (sts.full) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = sall_pkg::ST_FULL;
            end else begin
              cmd.start_walk = 1'b1;
            end
          end
          sall_pkg::FN_DELETE: begin
            if (sts.empty) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = sall_pkg::ST_EMPTY;
            end else begin
              cmd.start_walk = 1'b1;
            end
          end
          sall_pkg::FN_SEARCH: cmd.start_walk = 1'b1;
          sall_pkg::FN_LIST: begin
            if (sts.head_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = sall_pkg::ST_EMPTY;
              cmd.clr_key    = 1'b1;
            end else begin
              cmd.start_walk = 1'b1;
            end
          end
          default: cmd.start_walk = 1'b0;
        endcase
      end
      sall_pkg::S_WALK: begin
        cmd.step = !sts.key_ge;
      end
      sall_pkg::S_DECIDE: begin
        unique case (sts.func)
          sall_pkg::FN_INSERT: begin
            if (sts.found) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = sall_pkg::ST_DUP;
              cmd.slot_sel   = sall_pkg::SLOT_CUR;
            end else begin
              cmd.scan_init = 1'b1;
            end
          end
          sall_pkg::FN_DELETE: begin
            cmd.set_res = 1'b1;
            if (sts.found) begin
              cmd.unlink     = 1'b1;
              cmd.res_status = sall_pkg::ST_REMOVED;
              cmd.slot_sel   = sall_pkg::SLOT_CUR;
            end else begin
              cmd.res_status = sall_pkg::ST_NOTFOUND;
            end
          end
          sall_pkg::FN_SEARCH: begin
            cmd.set_res = 1'b1;
            if (sts.found) begin
              cmd.res_status = sall_pkg::ST_FOUND;
              cmd.slot_sel   = sall_pkg::SLOT_CUR;
            end else begin
              cmd.res_status = sall_pkg::ST_NOTFOUND;
            end
          end
          default: cmd.set_res = 1'b0;
        endcase
      end
      sall_pkg::S_SCAN: begin
        if (!sts.free_hit) begin
          if (sts.scan_end) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = sall_pkg::ST_FULL;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end
      end
      sall_pkg::S_LINK_NEW: cmd.link_new = 1'b1;
      sall_pkg::S_LINK_PREV: begin
        cmd.link_prev  = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = sall_pkg::ST_INSERTED;
        cmd.slot_sel   = sall_pkg::SLOT_FREE;
      end
      sall_pkg::S_RESP: cmd.emit_res = sts.out_free;
      sall_pkg::S_LIST: begin
        cmd.emit_list = sts.out_free;
        cmd.step      = sts.out_free && !sts.list_end;
      end
      default: req_ready = 1'b0;
    endcase
  end

  assign state_out = state;

endmodule

### hw/rtl/sall_datapath.sv
// Datapath: link and key stores, walk cursors, free flags, entry count and result register.
module sall_datapath #(
  parameter int CAPACITY = sall_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = sall_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  func,
  input  logic [sall_pkg::KEY_W-1:0]  key,
  input  sall_pkg::cmd_t              cmd,
  output sall_pkg::sts_t              sts,
  input  logic                        rsp_ready,
  output logic                        rsp_valid,
  output logic [2:0]                  status,
  output logic [sall_pkg::KEY_W-1:0]  key_out,
  output logic [sall_pkg::SLOT_W-1:0] slot,
  output logic [sall_pkg::COUNT_W-1:0] entry_count,
  output logic                        last
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int KEY_W   = sall_pkg::KEY_W;
  localparam int SLOT_W  = sall_pkg::SLOT_W;
  localparam int COUNT_W = sall_pkg::COUNT_W;
  localparam int LIST_W  = sall_pkg::LIST_W;

  // cell 0 is the head sentinel; its link lives in head, not in link_mem
  logic [KEY_BITS-1:0] key_mem  [CAPACITY];
  logic [IDX_W-1:0]    link_mem [CAPACITY];

  sall_pkg::func_t     func_q;
  logic [KEY_BITS-1:0] key_q;
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    cur;
  logic [IDX_W-1:0]    prev;
  logic [KEY_BITS-1:0] key_rd;
  logic [IDX_W-1:0]    link_rd;
  logic [IDX_W-1:0]    scan_j;
  logic [IDX_W-1:0]    used_cnt;
  logic [CAPACITY-1:0] free_q;
  logic [LIST_W-1:0]   list_n;
  sall_pkg::status_t   res_status;
  logic [IDX_W-1:0]    res_slot;

  sall_pkg::status_t   out_status;
  logic [KEY_W-1:0]    out_key;
  logic [SLOT_W-1:0]   out_slot;
  logic [COUNT_W-1:0]  out_count;
  logic                out_last;
  logic                out_valid;

  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                lw_en;
  logic                head_we;
  logic [IDX_W-1:0]    lw_data;
  logic                list_end;

  assign rd_en   = cmd.start_walk || cmd.step;
  assign rd_addr = cmd.start_walk ? head : link_rd;

  // predecessor link update: head register when the predecessor is the sentinel
  always_comb begin
    lw_en   = 1'b0;
    head_we = 1'b0;
    lw_data = link_rd;
    if (cmd.unlink || cmd.link_prev) begin
      lw_data = cmd.link_prev ? scan_j : link_rd;
      if (prev == '0) head_we = 1'b1;
      else lw_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_rd  <= key_mem[rd_addr];
      link_rd <= link_mem[rd_addr];
    end
    if (cmd.link_new) begin
      link_mem[scan_j] <= cur;
      key_mem[scan_j]  <= key_q;
    end else if (lw_en) begin
      link_mem[prev] <= lw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      used_cnt  <= '0;
      free_q    <= {{(CAPACITY-1){1'b1}}, 1'b0};
      out_valid <= 1'b0;
    end else begin
      if (head_we) head <= lw_data;
      if (cmd.unlink) begin
        free_q[cur] <= 1'b1;
        used_cnt    <= used_cnt - IDX_W'(1);
      end
      if (cmd.link_new) free_q[scan_j] <= 1'b0;
      if (cmd.link_prev) used_cnt <= used_cnt + IDX_W'(1);
      if (cmd.emit_res || cmd.emit_list) out_valid <= 1'b1;
      else if (rsp_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_q <= sall_pkg::func_t'(func);
      key_q  <= key[KEY_BITS-1:0];
    end else if (cmd.clr_key) begin
      key_q <= '0;
    end
    if (cmd.start_walk) begin
      prev   <= '0;
      cur    <= head;
      list_n <= '0;
    end else if (cmd.step) begin
      prev <= cur;
      cur  <= link_rd;
    end
    if (cmd.emit_list) list_n <= list_n + LIST_W'(1);
    if (cmd.scan_init) scan_j <= IDX_W'(1);
    else if (cmd.scan_step) scan_j <= scan_j + IDX_W'(1);
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      case (cmd.slot_sel)
        sall_pkg::SLOT_CUR:  res_slot <= cur;
        sall_pkg::SLOT_FREE: res_slot <= scan_j;
        default:             res_slot <= '0;
      endcase
    end
    if (cmd.emit_res) begin
      out_status <= res_status;
      out_key    <= KEY_W'(key_q);
      out_slot   <= SLOT_W'(res_slot);
      out_count  <= COUNT_W'(used_cnt);
      out_last   <= 1'b1;
    end else if (cmd.emit_list) begin
      out_status <= sall_pkg::ST_LISTED;
      out_key    <= KEY_W'(key_rd);
      out_slot   <= SLOT_W'(cur);
      out_count  <= COUNT_W'(used_cnt);
      out_last   <= list_end;
    end
  end

  assign list_end = (link_rd == '0) || (list_n == LIST_W'(sall_pkg::MAX_OUT - 1));

  always_comb begin
    sts.func      = func_q;
    sts.full      = used_cnt >= IDX_W'(CAPACITY - 1);
    sts.empty     = used_cnt == '0;
    sts.head_zero = head == '0;
    sts.link_zero = link_rd == '0;
    sts.key_ge    = key_rd >= key_q;
    sts.found     = (cur != '0) && (key_rd == key_q);
    sts.free_hit  = free_q[scan_j];
    sts.scan_end  = scan_j == IDX_W'(CAPACITY - 1);
    sts.list_end  = list_end;
    sts.out_free  = !out_valid || rsp_ready;
  end

  assign rsp_valid   = out_valid;
  assign status      = out_status;
  assign key_out     = out_key;
  assign slot        = out_slot;
  assign entry_count = out_count;
  assign last        = out_last;

endmodule

### hw/rtl/sorted_array_linked_list.sv
// Sorted linked list of keys in an array of cells: top level with controller and datapath.
// Insert walks up to CAPACITY-1 link steps (one per cycle through the registered store read)
// and then scans up to CAPACITY-1 cells for a free one. Delete and search walk the same way;
// list gives one key per cycle while the output register is free to take it.
// One item at a time; the next item is taken while the final result still waits in the
// output register. Reset clears control, entry count and free flags; the key
// store is not cleared and needs no clearing pass.
module sorted_array_linked_list #(
  parameter int CAPACITY = sall_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = sall_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [1:0]                   func,
  input  logic [sall_pkg::KEY_W-1:0]   key,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [2:0]                   status,
  output logic [sall_pkg::KEY_W-1:0]   key_out,
  output logic [sall_pkg::SLOT_W-1:0]  slot,
  output logic [sall_pkg::COUNT_W-1:0] entry_count,
  output logic                         last
);

  sall_pkg::cmd_t   cmd;
  sall_pkg::sts_t   sts;
  sall_pkg::state_t state;

  sall_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd),
    .state_out (state)
  );

  sall_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .key         (key),
    .cmd         (cmd),
    .sts         (sts),
    .rsp_ready   (rsp_ready),
    .rsp_valid   (rsp_valid),
    .status      (status),
    .key_out     (key_out),
    .slot        (slot),
    .entry_count (entry_count),
    .last        (last)
  );

  // a newly linked cell must no longer show as free
  a_claimed_cell: assert property (@(posedge clk) disable iff (rst)
    cmd.link_new |=> !sts.free_hit)
    else $error("claimed cell still marked free");

  // an insert walk only starts with room left in the list
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == sall_pkg::S_START && sts.func == sall_pkg::FN_INSERT && cmd.start_walk)
      |-> !sts.full)
    else $error("insert walk started on a full list");

  // unlinking only happens on a matched key in a non-empty list
  a_unlink_match: assert property (@(posedge clk) disable iff (rst)
    cmd.unlink |-> (sts.found && !sts.empty))
    else $error("unlink without a matching entry");

  // a single-result item always ends with last set
  a_resp_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_res |=> (rsp_valid && last && state == sall_pkg::S_IDLE))
    else $error("single result item did not close with last");

endmodule

### test/sorted_array_linked_list_tb.sv
// Testbench for the sorted array linked list: queued driver, monitor and list predictor.
`timescale 1ns / 100ps

module sorted_array_linked_list_tb;

  localparam int CAP          = sall_pkg::CAPACITY_DEF;
  localparam int RAND_ITEMS   = 260;
  localparam int POOL_SIZE    = 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    sall_pkg::func_t f;
    logic [63:0]     k;
  } list_op_t;

  typedef struct {
    sall_pkg::status_t status;
    logic [63:0]       key_out;
    logic [3:0]        slot;
    logic [3:0]        entry_count;
    logic              last;
  } list_rsp_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_ready;
  sall_pkg::func_t func = sall_pkg::FN_INSERT;
  logic [63:0]     key = '0;
  logic            rsp_valid;
  logic            rsp_ready = 1'b0;
  logic [2:0]      status;
  logic [63:0]     key_out;
  logic [3:0]      slot;
  logic [3:0]      entry_count;
  logic            last;

  list_op_t    op_queue[$];
  list_rsp_t   rsp_expect[$];
  logic [63:0] key_pool[POOL_SIZE];
  int          total_ops;
  int          accepted_ops = 0;
  int          err_count = 0;
  int          cycle_count = 0;
  logic        req_fire = 1'b0;

  // predictor state
  int unsigned cell_next[CAP];
  bit          cell_free[CAP];
  logic [63:0] cell_key[CAP];
  int unsigned entry_total;

  sorted_array_linked_list u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .func        (func),
    .key         (key),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .key_out     (key_out),
    .slot        (slot),
    .entry_count (entry_count),
    .last        (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle percentage: receiver heavy first, then sender heavy, then none
  function automatic int idle_pct(bit rx_side);
    int third;
    third = (total_ops == 0) ? 0 : (accepted_ops * 3) / total_ops;
    if (third == 0) return rx_side ? 64 : 35;
    if (third == 1) return rx_side ? 35 : 64;
    return 0;
  endfunction

  task automatic push_result(sall_pkg::status_t st, logic [63:0] k, int unsigned idx,
                             bit fin);
    list_rsp_t r;
    r.status      = st;
    r.key_out     = k;
    r.slot        = 4'(idx);
    r.entry_count = 4'(entry_total);
    r.last        = fin;
    rsp_expect.push_back(r);
  endtask

  // cell holding k (0 if absent), with its predecessor
  function automatic int unsigned find_cell(logic [63:0] k, output int unsigned prev);
    int unsigned cur, steps;
    prev  = 0;
    cur   = cell_next[0];
    steps = 0;
    while (cur != 0 && steps < CAP) begin
      if (cell_key[cur] == k) break;
      prev = cur;
      cur  = cell_next[cur];
      steps++;
    end
    if (steps >= CAP) cur = 0;
    return cur;
  endfunction

  task automatic predict_list_op(sall_pkg::func_t f, logic [63:0] k);
    int unsigned prev, cur, steps, j, nx, n;
    bit          fin;
    case (f)
      sall_pkg::FN_INSERT: begin
        if (entry_total >= CAP - 1) begin
          push_result(sall_pkg::ST_FULL, k, 0, 1'b1);
        end else begin
          cur = find_cell(k, prev);
          if (cur != 0) begin
            push_result(sall_pkg::ST_DUP, k, cur, 1'b1);
          end else begin
            j = 1;
            while (j < CAP && !cell_free[j]) j++;
            if (j >= CAP) begin
              push_result(sall_pkg::ST_FULL, k, 0, 1'b1);
            end else begin
              prev  = 0;
              cur   = cell_next[0];
              steps = 0;
              while (cur != 0 && steps < CAP && cell_key[cur] <= k) begin
                prev = cur;
                cur  = cell_next[cur];
                steps++;
              end
              if (steps >= CAP) cur = 0;
              cell_next[j]    = cur;
              cell_free[j]    = 1'b0;
              cell_next[prev] = j;
              cell_key[j]     = k;
              entry_total++;
              push_result(sall_pkg::ST_INSERTED, k, j, 1'b1);
            end
          end
        end
      end
      sall_pkg::FN_DELETE: begin
        if (entry_total == 0) begin
          push_result(sall_pkg::ST_EMPTY, k, 0, 1'b1);
        end else begin
          cur = find_cell(k, prev);
          if (cur == 0) begin
            push_result(sall_pkg::ST_NOTFOUND, k, 0, 1'b1);
          end else begin
            cell_next[prev] = cell_next[cur];
            cell_next[cur]  = 0;
            cell_free[cur]  = 1'b1;
            entry_total--;
            push_result(sall_pkg::ST_REMOVED, k, cur, 1'b1);
          end
        end
      end
      sall_pkg::FN_SEARCH: begin
        cur = find_cell(k, prev);
        push_result((cur != 0) ? sall_pkg::ST_FOUND : sall_pkg::ST_NOTFOUND, k, cur, 1'b1);
      end
      default: begin
        cur = cell_next[0];
        if (cur == 0) begin
          push_result(sall_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else begin
          n     = 0;
          steps = 0;
          while (cur != 0 && n < sall_pkg::MAX_OUT && steps < CAP) begin
            nx  = cell_next[cur];
            fin = (nx == 0) || (n + 1 >= sall_pkg::MAX_OUT) || (steps + 1 >= CAP);
            push_result(sall_pkg::ST_LISTED, cell_key[cur], cur, fin);
            n++;
            steps++;
            cur = nx;
          end
        end
      end
    endcase
  endtask

  task automatic queue_op(sall_pkg::func_t f, logic [63:0] k);
    list_op_t op;
    op.f = f;
    op.k = k;
    op_queue.push_back(op);
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  // driver: new payload only once the previous item was taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= idle_pct(1'b1));
      if (!req_valid || req_fire) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          req_valid <= 1'b1;
          func      <= op_queue[0].f;
          key       <= op_queue[0].k;
          op_queue.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on accepted items, check accepted results
  always @(posedge clk) begin
    list_rsp_t exp_rsp;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
    req_fire <= !rst && req_valid && req_ready;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (rsp_expect.size() == 0) begin
          $error("result with nothing expected: status %0d key_out %h", status, key_out);
          err_count++;
        end else begin
          exp_rsp = rsp_expect.pop_front();
          if (status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, status);
            err_count++;
          end
          if (key_out !== exp_rsp.key_out) begin
            $error("key_out: expected %h, got %h", exp_rsp.key_out, key_out);
            err_count++;
          end
          if (slot !== exp_rsp.slot) begin
            $error("slot: expected %0d, got %0d", exp_rsp.slot, slot);
            err_count++;
          end
          if (entry_count !== exp_rsp.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_rsp.entry_count, entry_count);
            err_count++;
          end
          if (last !== exp_rsp.last) begin
            $error("last: expected %0d, got %0d", exp_rsp.last, last);
            err_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        predict_list_op(func, key);
        accepted_ops++;
      end
    end
  end

  initial begin
    int              i, n_seg, seg_len, r;
    bit              first_seg;
    sall_pkg::func_t f;

    for (i = 0; i < CAP; i++) begin
      cell_next[i] = 0;
      cell_free[i] = (i != 0);
    end
    entry_total = 0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    key_pool[3] = 64'h7FFF_FFFF_FFFF_FFFF;
    key_pool[4] = {"DELTA", 24'd0};
    for (i = 5; i < POOL_SIZE; i++)
      key_pool[i] = (i % 4 == 0) ? key_pool[i - 1] + 1 : {$urandom, $urandom};

    // directed: empty list cases, extremes, duplicate, absent key
    queue_op(sall_pkg::FN_LIST,   {$urandom, $urandom});
    queue_op(sall_pkg::FN_DELETE, 64'h0000_0000_0000_1234);
    queue_op(sall_pkg::FN_SEARCH, '0);
    queue_op(sall_pkg::FN_INSERT, '0);
    queue_op(sall_pkg::FN_INSERT, '1);
    queue_op(sall_pkg::FN_INSERT, '0);
    queue_op(sall_pkg::FN_INSERT, {"ALPHA", 24'd0});
    queue_op(sall_pkg::FN_SEARCH, '1);
    queue_op(sall_pkg::FN_DELETE, 64'd5);
    queue_op(sall_pkg::FN_LIST,   '1);
    queue_op(sall_pkg::FN_DELETE, '0);
    queue_op(sall_pkg::FN_DELETE, '1);
    queue_op(sall_pkg::FN_SEARCH, '0);
    queue_op(sall_pkg::FN_LIST,   '0);

    // random: fill, drain and mixed runs; the first run is mostly inserts of fresh keys
    n_seg     = RAND_ITEMS;
    first_seg = 1'b1;
    while (op_queue.size() < n_seg) begin
      r       = first_seg ? 0 : $urandom_range(2);
      seg_len = first_seg ? 18 : $urandom_range(8, 20);
      for (i = 0; i < seg_len; i++) begin
        case (r)
          0:       f = ($urandom_range(99) < 85) ? sall_pkg::FN_INSERT : sall_pkg::FN_SEARCH;
          1:       f = ($urandom_range(99) < 80) ? sall_pkg::FN_DELETE :
                       ($urandom_range(1) != 0) ? sall_pkg::FN_SEARCH : sall_pkg::FN_LIST;
          default: f = sall_pkg::func_t'($urandom_range(3));
        endcase
        queue_op(f, first_seg ? {$urandom, $urandom} : pick_key());
      end
      if (r != 2) queue_op(sall_pkg::FN_LIST, {$urandom, $urandom});
      first_seg = 1'b0;
    end
    total_ops = op_queue.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(accepted_ops == total_ops && rsp_expect.size() == 0)) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0 && rsp_expect.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
